FILE: src/muskingum_channel_route_floodplain_macros.svh
// assertion macros for the muskingum channel routing block
// no dependencies; included by the top level
`ifndef MUSKINGUM_CHANNEL_ROUTE_FLOODPLAIN_MACROS_SVH
`define MUSKINGUM_CHANNEL_ROUTE_FLOODPLAIN_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MCRF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MCRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MCRF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MCRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/mcrf_pkg.sv
// shared widths, types and helpers for the muskingum routing block
// no dependencies
package mcrf_pkg;

   localparam int NUM_CELLS = 4096;
   localparam int ADDR_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int CELL_W    = 12;
   localparam int FLOW_W    = 32;
   localparam int COEF_W    = 18;
   localparam int VOL_W     = 56;
   localparam int CHG_W     = 57;
   localparam int STEP_W    = 17;
   localparam int QUOT_W    = 32;
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(86400);

   // per-cell state word kept in the state memory
   typedef struct packed {
      logic [FLOW_W-1:0] prev_in;
      logic [FLOW_W-1:0] prev_out;
      logic [VOL_W-1:0]  chan_vol;
      logic [VOL_W-1:0]  fp_vol;
   } cell_state_type;

   localparam int STATE_W = $bits(cell_state_type);

   // divider control and status
   typedef struct packed {
      logic start;
      logic ack;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // cell index to memory address, compare-subtract by shifted cell count
   function automatic logic [ADDR_W-1:0] cell_index(input logic [CELL_W-1:0] cell_num);
      logic [63:0] rem;
      logic [63:0] sub;
      rem = 64'(cell_num);
      for (int i = CELL_W - 1; i >= 0; i--) begin
         sub = 64'(NUM_CELLS) << i;
         if (rem >= sub) begin
            rem = rem - sub;
         end
      end
      return rem[ADDR_W-1:0];
   endfunction

endpackage

FILE: src/mcrf_if.sv
// request and response channel interfaces for the muskingum routing block
// depends on mcrf_pkg
interface mcrf_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [mcrf_pkg::CELL_W-1:0]            cell_req;
   logic [mcrf_pkg::FLOW_W-1:0]            upstream_discharge;
   logic [mcrf_pkg::FLOW_W-1:0]            runoff_flow;
   logic [mcrf_pkg::FLOW_W-1:0]            bankfull_discharge;
   logic signed [mcrf_pkg::COEF_W-1:0]     coeff_current_in;
   logic signed [mcrf_pkg::COEF_W-1:0]     coeff_previous_in;
   logic signed [mcrf_pkg::COEF_W-1:0]     coeff_previous_out;

   modport source (output valid, cell_req, upstream_discharge, runoff_flow,
                   bankfull_discharge, coeff_current_in, coeff_previous_in,
                   coeff_previous_out, input ready);
   modport sink (input valid, cell_req, upstream_discharge, runoff_flow,
                 bankfull_discharge, coeff_current_in, coeff_previous_in,
                 coeff_previous_out, output ready);
endinterface

interface mcrf_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [mcrf_pkg::CELL_W-1:0]            cell_out;
   logic [mcrf_pkg::FLOW_W-1:0]            capped_inflow;
   logic [mcrf_pkg::FLOW_W-1:0]            outflow;
   logic signed [mcrf_pkg::CHG_W-1:0]      storage_change;
   logic [mcrf_pkg::VOL_W-1:0]             channel_storage_out;
   logic [mcrf_pkg::VOL_W-1:0]             floodplain_out;

   modport source (output valid, cell_out, capped_inflow, outflow, storage_change,
                   channel_storage_out, floodplain_out, input ready);
   modport sink (input valid, cell_out, capped_inflow, outflow, storage_change,
                 channel_storage_out, floodplain_out, output ready);
endinterface

FILE: src/mcrf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mcrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: src/mcrf_div.sv
// iterative restoring divider, floodplain volume by step length, one bit a cycle
// depends on mcrf_pkg
module mcrf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  mcrf_pkg::div_ctl_type         ctl,
   input  logic [mcrf_pkg::VOL_W-1:0]    dividend,
   input  logic [mcrf_pkg::STEP_W-1:0]   divisor,
   output mcrf_pkg::div_stat_type        stat,
   output logic [mcrf_pkg::QUOT_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(mcrf_pkg::QUOT_W);
   localparam int SH_W  = mcrf_pkg::STEP_W + mcrf_pkg::QUOT_W - 1;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [mcrf_pkg::VOL_W-1:0]  rem_ff, rem_in;
   logic [SH_W-1:0]             dvs_ff, dvs_in;
   logic [mcrf_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [mcrf_pkg::VOL_W:0]    trial;

   // one trial subtraction per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      trial   = {1'b0, rem_ff} - (mcrf_pkg::VOL_W + 1)'(dvs_ff);
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(mcrf_pkg::QUOT_W - 1);
         rem_in  = dividend;
         dvs_in  = SH_W'(divisor) << (mcrf_pkg::QUOT_W - 1);
         quot_in = '0;
      end else if (busy_ff) begin
         if (!trial[mcrf_pkg::VOL_W]) begin
            rem_in          = trial[mcrf_pkg::VOL_W-1:0];
            quot_in[cnt_ff] = 1'b1;
         end
         dvs_in = dvs_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end else if (ctl.ack) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

FILE: src/muskingum_channel_route_floodplain.sv
// path: a request passes through stages 1 to 5 and then the output register; a request that
// releases a whole floodplain store also waits in stage 2 for the bit-serial divider
// throughput: one request a cycle for distinct cells unless the output is held or stage 2 waits
// on the divider; a request for a cell still in the pipeline waits until that cell's state is
// written back to the state memory. reset: clears control, then sweeps the 4096-entry state
// memory to zero before the first request is taken; step length resets to 86400
`include "muskingum_channel_route_floodplain_macros.svh"

module muskingum_channel_route_floodplain (
   input  logic                          clock,
   input  logic                          reset,
   mcrf_req_if.sink                      req_chan,
   mcrf_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [mcrf_pkg::STEP_W-1:0]   csr_write_data
);

   localparam int AW = mcrf_pkg::ADDR_W;
   localparam int FW = mcrf_pkg::FLOW_W;
   localparam int VW = mcrf_pkg::VOL_W;
   localparam int CW = mcrf_pkg::COEF_W;
   localparam int SW = mcrf_pkg::STEP_W;
   localparam int PW = FW + SW;

   // step length register
   logic [SW-1:0] step_ff;
   logic [SW-1:0] dt;
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mcrf_pkg::STEP_RESET;
      end else if (csr_write_enable) begin
         step_ff <= csr_write_data;
      end
   end
   assign dt = (step_ff == '0) ? SW'(1) : step_ff;

   // clearing sweep
   logic          clr_done_ff;
   logic [AW-1:0] clr_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_done_ff <= 1'b0;
         clr_cnt_ff  <= '0;
      end else if (!clr_done_ff) begin
         if (clr_cnt_ff == AW'(mcrf_pkg::NUM_CELLS - 1)) begin
            clr_done_ff <= 1'b1;
         end else begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
      end
   end

   // stage valids and per-stage fields
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, out_v_ff;
   logic [mcrf_pkg::CELL_W-1:0] s1_cell_ff, s2_cell_ff, s3_cell_ff, s4_cell_ff, s5_cell_ff;
   logic [AW-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff, s5_idx_ff;
   logic signed [CW-1:0] s1_c0_ff, s1_c1_ff, s1_c2_ff;
   logic signed [CW-1:0] s2_c0_ff, s2_c1_ff, s2_c2_ff;
   logic signed [CW-1:0] s3_c0_ff, s3_c1_ff, s3_c2_ff;
   logic [FW-1:0] s1_up_ff, s1_ro_ff, s1_bank_ff;

   // handshake chain
   logic out_free, go5, go4, go3, go2, go1, s2_ok, s2_move, hazard, accept;
   logic [AW-1:0] req_idx;
   mcrf_pkg::div_ctl_type  div_ctl;
   mcrf_pkg::div_stat_type div_stat;
   logic [mcrf_pkg::QUOT_W-1:0] div_q;
   logic need_div;

   assign req_idx  = mcrf_pkg::cell_index(req_chan.cell_req);
   assign out_free = !out_v_ff || rsp_chan.ready;
   assign go5      = !s5_v_ff || out_free;
   assign go4      = !s4_v_ff || go5;
   assign go3      = !s3_v_ff || go4;
   assign s2_ok    = !need_div || div_stat.done;
   assign s2_move  = s2_v_ff && s2_ok && go3;
   assign go2      = !s2_v_ff || s2_move;
   assign go1      = !s1_v_ff || go2;

   // interlock against a cell still in flight
   assign hazard = (s1_v_ff && s1_idx_ff == req_idx) || (s2_v_ff && s2_idx_ff == req_idx) ||
                   (s3_v_ff && s3_idx_ff == req_idx) || (s4_v_ff && s4_idx_ff == req_idx) ||
                   (s5_v_ff && s5_idx_ff == req_idx);
   assign req_chan.ready = clr_done_ff && go1 && !hazard;
   assign accept         = req_chan.valid && req_chan.ready;

   // state memory
   mcrf_pkg::cell_state_type ram_q, st1, st1_hold_ff, wb_state;
   logic                     ram_we;
   logic [AW-1:0]            ram_wa;
   logic                     rd_fresh_ff;
   logic                     wb_en;

   assign ram_we = !clr_done_ff || wb_en;
   assign ram_wa = clr_done_ff ? s5_idx_ff : clr_cnt_ff;

   mcrf_ram #(
      .WIDTH (mcrf_pkg::STATE_W),
      .DEPTH (mcrf_pkg::NUM_CELLS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (clr_done_ff ? wb_state : '0),
      .rd_addr (req_idx),
      .rd_data (ram_q)
   );

   // read data arrives in the cycle after the request is taken; keep it while stage 1 waits
   assign st1 = rd_fresh_ff ? ram_q : st1_hold_ff;

   // stage 1: inflow sum and floodplain transfer volume
   logic [FW:0]   in_sum;
   logic [FW-1:0] inflow1, diff1;
   logic          over1;
   logic [PW-1:0] vol1;
   always_comb begin
      in_sum  = {1'b0, s1_up_ff} + {1'b0, s1_ro_ff};
      inflow1 = in_sum[FW] ? '1 : in_sum[FW-1:0];
      over1   = inflow1 > s1_bank_ff;
      diff1   = over1 ? (inflow1 - s1_bank_ff) : (s1_bank_ff - inflow1);
      vol1    = PW'(diff1) * PW'(dt);
   end

   logic [FW-1:0] s2_inflow_ff, s2_bank_ff;
   logic          s2_over_ff;
   logic [PW-1:0] s2_vol_ff;
   mcrf_pkg::cell_state_type s2_st_ff;

   // stage 2: floodplain capping or release
   logic [VW:0]   fp_sum;
   logic [FW:0]   rel_sum;
   logic [FW-1:0] cap2;
   logic [VW-1:0] fp2;
   always_comb begin
      fp_sum   = {1'b0, s2_st_ff.fp_vol} + (VW + 1)'(s2_vol_ff);
      rel_sum  = {1'b0, s2_inflow_ff} + {1'b0, div_q};
      need_div = 1'b0;
      cap2     = s2_inflow_ff;
      fp2      = s2_st_ff.fp_vol;
      if (s2_over_ff) begin
         fp2  = fp_sum[VW] ? '1 : fp_sum[VW-1:0];
         cap2 = s2_bank_ff;
      end else if (s2_st_ff.fp_vol != '0) begin
         if (VW'(s2_vol_ff) < s2_st_ff.fp_vol) begin
            fp2  = s2_st_ff.fp_vol - VW'(s2_vol_ff);
            cap2 = s2_bank_ff;
         end else begin
            need_div = 1'b1;
            fp2      = '0;
            cap2     = rel_sum[FW] ? '1 : rel_sum[FW-1:0];
         end
      end
   end

   assign div_ctl.start = s2_v_ff && need_div && !div_stat.busy && !div_stat.done;
   assign div_ctl.ack   = s2_move && need_div;

   mcrf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (s2_st_ff.fp_vol),
      .divisor  (dt),
      .stat     (div_stat),
      .quotient (div_q)
   );

   logic [FW-1:0] s3_cap_ff, s3_pin_ff, s3_pout_ff;
   logic [VW-1:0] s3_chan_ff, s3_fp_ff;

   // stage 3: the three weighted products
   logic signed [FW+CW:0] p0, p1, p2;
   always_comb begin
      p0 = s3_c0_ff * $signed({1'b0, s3_cap_ff});
      p1 = s3_c1_ff * $signed({1'b0, s3_pin_ff});
      p2 = s3_c2_ff * $signed({1'b0, s3_pout_ff});
   end

   logic signed [FW+CW:0] s4_p0_ff, s4_p1_ff, s4_p2_ff;
   logic [FW-1:0] s4_cap_ff;
   logic [VW-1:0] s4_chan_ff, s4_fp_ff;

   // stage 4: weighted sum and outflow
   logic signed [FW+CW+2:0] wsum;
   logic [FW-1:0]           outf4;
   always_comb begin
      wsum = (FW + CW + 3)'(s4_p0_ff) + (FW + CW + 3)'(s4_p1_ff) + (FW + CW + 3)'(s4_p2_ff);
      if (wsum < 0) begin
         outf4 = s4_cap_ff;
      end else if (wsum[FW+CW+2:FW+16] != '0) begin
         outf4 = '1;
      end else begin
         outf4 = wsum[FW+15:16];
      end
   end

   logic [FW-1:0] s5_cap_ff, s5_outf_ff;
   logic [VW-1:0] s5_chan_ff, s5_fp_ff;

   // stage 5: storage change product, registered into s5_chg_ff
   logic signed [FW:0]    dflow;
   logic signed [FW+SW:0] chg5;
   logic signed [FW+SW:0] s5_chg_ff;
   always_comb begin
      dflow = $signed({1'b0, s4_cap_ff}) - $signed({1'b0, outf4});
      chg5  = dflow * $signed({1'b0, dt});
   end

   // stage 5 to output: storage update and write-back
   logic signed [VW+1:0]             new_stor;
   logic [VW-1:0]                    stor_o;
   logic signed [mcrf_pkg::CHG_W-1:0] chg_o;
   logic [FW-1:0]                    outf_o;
   always_comb begin
      new_stor = $signed({2'b00, s5_chan_ff}) + (VW + 2)'(s5_chg_ff);
      if (new_stor > 0) begin
         stor_o = new_stor[VW] ? '1 : new_stor[VW-1:0];
         chg_o  = (mcrf_pkg::CHG_W)'(s5_chg_ff);
         outf_o = s5_outf_ff;
      end else begin
         stor_o = s5_chan_ff;
         chg_o  = '0;
         outf_o = s5_cap_ff;
      end
      wb_state.prev_in  = s5_cap_ff;
      wb_state.prev_out = outf_o;
      wb_state.chan_vol = stor_o;
      wb_state.fp_vol   = s5_fp_ff;
   end
   assign wb_en = s5_v_ff && out_free;

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         s4_v_ff     <= 1'b0;
         s5_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
         rd_fresh_ff <= 1'b0;
      end else begin
         rd_fresh_ff <= accept;
         if (go1) s1_v_ff <= accept;
         if (go2) s2_v_ff <= s1_v_ff;
         if (go3) s3_v_ff <= s2_move;
         if (go4) s4_v_ff <= s3_v_ff;
         if (go5) s5_v_ff <= s4_v_ff;
         if (out_free) out_v_ff <= s5_v_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      st1_hold_ff <= st1;
      if (go1) begin
         s1_cell_ff <= req_chan.cell_req;
         s1_idx_ff  <= req_idx;
         s1_up_ff   <= req_chan.upstream_discharge;
         s1_ro_ff   <= req_chan.runoff_flow;
         s1_bank_ff <= req_chan.bankfull_discharge;
         s1_c0_ff   <= req_chan.coeff_current_in;
         s1_c1_ff   <= req_chan.coeff_previous_in;
         s1_c2_ff   <= req_chan.coeff_previous_out;
      end
      if (go2) begin
         s2_cell_ff   <= s1_cell_ff;
         s2_idx_ff    <= s1_idx_ff;
         s2_c0_ff     <= s1_c0_ff;
         s2_c1_ff     <= s1_c1_ff;
         s2_c2_ff     <= s1_c2_ff;
         s2_inflow_ff <= inflow1;
         s2_bank_ff   <= s1_bank_ff;
         s2_over_ff   <= over1;
         s2_vol_ff    <= vol1;
         s2_st_ff     <= st1;
      end
      if (go3) begin
         s3_cell_ff <= s2_cell_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_c0_ff   <= s2_c0_ff;
         s3_c1_ff   <= s2_c1_ff;
         s3_c2_ff   <= s2_c2_ff;
         s3_cap_ff  <= cap2;
         s3_pin_ff  <= s2_st_ff.prev_in;
         s3_pout_ff <= s2_st_ff.prev_out;
         s3_chan_ff <= s2_st_ff.chan_vol;
         s3_fp_ff   <= fp2;
      end
      if (go4) begin
         s4_cell_ff <= s3_cell_ff;
         s4_idx_ff  <= s3_idx_ff;
         s4_p0_ff   <= p0;
         s4_p1_ff   <= p1;
         s4_p2_ff   <= p2;
         s4_cap_ff  <= s3_cap_ff;
         s4_chan_ff <= s3_chan_ff;
         s4_fp_ff   <= s3_fp_ff;
      end
      if (go5) begin
         s5_cell_ff <= s4_cell_ff;
         s5_idx_ff  <= s4_idx_ff;
         s5_cap_ff  <= s4_cap_ff;
         s5_outf_ff <= outf4;
         s5_chg_ff  <= chg5;
         s5_chan_ff <= s4_chan_ff;
         s5_fp_ff   <= s4_fp_ff;
      end
      if (out_free) begin
         rsp_chan.cell_out            <= s5_cell_ff;
         rsp_chan.capped_inflow       <= s5_cap_ff;
         rsp_chan.outflow             <= outf_o;
         rsp_chan.storage_change      <= chg_o;
         rsp_chan.channel_storage_out <= stor_o;
         rsp_chan.floodplain_out      <= s5_fp_ff;
      end
   end

   assign rsp_chan.valid = out_v_ff;

   // checks
   `MCRF_ASSERT_IMPLY(a_no_req_in_clear, clock, reset, accept, clr_done_ff)
   `MCRF_ASSERT_IMPLY(a_div_done_has_item, clock, reset, div_stat.done, s2_v_ff && need_div)
   `MCRF_ASSERT_IMPLY(a_wb_from_stage5, clock, reset, ram_we && clr_done_ff, s5_v_ff)
   `MCRF_ASSERT_IMPLY(a_no_dup_cell, clock, reset, s1_v_ff && s2_v_ff, s1_idx_ff != s2_idx_ff)
   `MCRF_ASSERT_NEXT(a_read_fresh, clock, reset, accept, rd_fresh_ff && s1_v_ff)

endmodule
